// ===== design/lrc_pkg.sv =====
// ---------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants for the LRU result cache table.
// ---------------------------------------------------------------------------
package lrc_pkg;

    localparam int LRC_DEPTH  = 16;
    localparam int CAP_W      = 5;
    localparam int KEY_W      = 64;
    localparam int TID_W      = 32;
    localparam int HND_W      = 32;
    localparam int REQ_W      = 2;
    localparam int REMOVED_W  = 5;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 40;

    localparam logic [CAP_W-1:0]     CAP_RESET   = 5'd16;
    localparam logic [REMOVED_W-1:0] REMOVED_MAX = 5'd31;

    localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DROP = 2'd2;

    // key in the lowest bits
    typedef struct packed {
        logic [HND_W-1:0] handle;
        logic             drp;
        logic [TID_W-1:0] tid;
        logic [KEY_W-1:0] key;
    } entry_t;

    localparam int LRC_ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EX,
        ST_DECIDE,
        ST_UPD_RD,
        ST_UPD_EX,
        ST_MAP,
        ST_FIX_RD,
        ST_FIX_MAP,
        ST_FIX_EX,
        ST_DONE
    } state_t;

endpackage

// ===== design/lrc_ram.sv =====
// ---------------------------------------------------------------------------
// lrc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lrc_ram #(
    parameter int WIDTH = lrc_pkg::LRC_ENTRY_W,
    parameter int DEPTH = lrc_pkg::LRC_DEPTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/lru_result_cache_table_top.sv =====
// ---------------------------------------------------------------------------
// lru_result_cache_table_top
// Fully associative LRU store of query-result entries: add, get, drop.
// ---------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  tuser: req_type; tdata: key, table, flag, handle
// m_       out  m_tvalid/m_tready  tdata: found, inserted, result_handle, removed_count
// cfg_     in   cfg_valid/cfg_ready cfg_data: capacity
//
// Each request is handled by a sequencer sweeping the slots through one compare
// unit. Add hit, get miss and unused codes take the scan pass only. Add miss and
// get hit add a recency update pass; drop adds a map pass and a fix pass when any
// entry goes. Slot payload and recency ranks sit in RAMs with registered reads.
// After reset the store is empty and capacity is 16. A stalled result is held
// in the output register; the next request is accepted, but its result waits
// in the last state until the held one has been taken.
// ---------------------------------------------------------------------------
module lru_result_cache_table_top #(
    parameter int DEPTH = lrc_pkg::LRC_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [63:0] entry_key, [95:64] table_id, [96] droppable, [128:97] content_handle
    input  logic [lrc_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] req_type
    input  logic [lrc_pkg::REQ_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] found, [1] inserted, [33:2] result_handle, [38:34] removed_count
    output logic [lrc_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lrc_pkg::CAP_W-1:0]        cfg_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > lrc_pkg::CAP_W) ? CNT_W : lrc_pkg::CAP_W;
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
    localparam logic [CW-1:0]    CAP_DEPTH = CW'(DEPTH);
    localparam logic [CW-1:0]    CAP_ONE   = CW'(1);

    lrc_pkg::state_t state_reg;
    lrc_pkg::state_t state_next;

    logic [IDX_W-1:0]            idx_reg;
    logic [DEPTH-1:0]            valid_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [lrc_pkg::CAP_W-1:0]   capacity_reg;
    logic [DEPTH-1:0]            kill_reg;
    logic [DEPTH-1:0]            kill_rank_reg;
    logic [CNT_W-1:0]            n_reg;
    logic [CNT_W-1:0]            cum_reg;
    logic                        hit_reg;
    logic                        victim_have_reg;
    logic                        free_have_reg;
    logic                        m_tvalid_reg;

    logic [IDX_W-1:0]            slot_reg;
    logic [IDX_W-1:0]            victim_reg;
    logic [IDX_W-1:0]            free_reg;
    logic [IDX_W-1:0]            best_reg;
    logic [IDX_W-1:0]            hit_rank_reg;
    logic [lrc_pkg::HND_W-1:0]   hit_handle_reg;
    logic [lrc_pkg::REQ_W-1:0]   req_reg;
    lrc_pkg::entry_t             in_reg;
    logic                        res_found_reg;
    logic                        res_inserted_reg;
    logic [lrc_pkg::HND_W-1:0]   res_handle_reg;
    logic [lrc_pkg::REMOVED_W-1:0] res_removed_reg;
    logic [lrc_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    lrc_pkg::entry_t             ent_rd_data;
    logic                        ent_wr_en;
    logic [IDX_W-1:0]            rank_rd_data;
    logic [IDX_W-1:0]            rank_wr_data;
    logic                        rank_wr_en;
    logic [IDX_W-1:0]            map_rd_data;
    logic [IDX_W-1:0]            map_wr_data;
    logic                        map_wr_en;

    logic                        s_accept;
    logic                        idx_last;
    logic                        out_free;
    logic                        slot_valid;
    logic                        key_eq;
    logic                        tid_kill;
    logic                        full;
    logic [CW-1:0]               cap_ext;
    logic [CW-1:0]               cap_eff;
    logic [CW-1:0]               n_ext;

    assign s_accept   = s_tvalid && s_tready;
    assign idx_last   = (idx_reg == IDX_LAST);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign slot_valid = valid_reg[idx_reg];

    // shared compare unit
    assign key_eq   = slot_valid && (ent_rd_data.key == in_reg.key);
    assign tid_kill = slot_valid && ent_rd_data.drp && (ent_rd_data.tid == in_reg.tid);

    assign cap_ext = CW'(capacity_reg);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            cap_eff = CAP_ONE;
        end
        else if (cap_ext > CAP_DEPTH)
        begin
            cap_eff = CAP_DEPTH;
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end
    assign full  = (CW'(count_reg) >= cap_eff) && (count_reg != '0);
    assign n_ext = CW'(n_reg);

    lrc_ram #(
        .WIDTH(lrc_pkg::LRC_ENTRY_W),
        .DEPTH(DEPTH)
    ) u_entry_ram (
        .clk    (clk),
        .wr_en  (ent_wr_en),
        .wr_addr(idx_reg),
        .wr_data(in_reg),
        .rd_addr(idx_reg),
        .rd_data(ent_rd_data)
    );

    lrc_ram #(
        .WIDTH(IDX_W),
        .DEPTH(DEPTH)
    ) u_rank_ram (
        .clk    (clk),
        .wr_en  (rank_wr_en),
        .wr_addr(idx_reg),
        .wr_data(rank_wr_data),
        .rd_addr(idx_reg),
        .rd_data(rank_rd_data)
    );

    lrc_ram #(
        .WIDTH(IDX_W),
        .DEPTH(DEPTH)
    ) u_remap_ram (
        .clk    (clk),
        .wr_en  (map_wr_en),
        .wr_addr(idx_reg),
        .wr_data(map_wr_data),
        .rd_addr(rank_rd_data),
        .rd_data(map_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = lrc_pkg::ST_SCAN_RD;
                end
            end
            lrc_pkg::ST_SCAN_RD:
            begin
                state_next = lrc_pkg::ST_SCAN_EX;
            end
            lrc_pkg::ST_SCAN_EX:
            begin
                state_next = idx_last ? lrc_pkg::ST_DECIDE : lrc_pkg::ST_SCAN_RD;
            end
            lrc_pkg::ST_DECIDE:
            begin
                case (req_reg)
                    lrc_pkg::REQ_ADD:
                    begin
                        state_next = hit_reg ? lrc_pkg::ST_DONE : lrc_pkg::ST_UPD_RD;
                    end
                    lrc_pkg::REQ_GET:
                    begin
                        state_next = hit_reg ? lrc_pkg::ST_UPD_RD : lrc_pkg::ST_DONE;
                    end
                    lrc_pkg::REQ_DROP:
                    begin
                        state_next = (n_reg == '0) ? lrc_pkg::ST_DONE : lrc_pkg::ST_MAP;
                    end
                    default:
                    begin
                        state_next = lrc_pkg::ST_DONE;
                    end
                endcase
            end
            lrc_pkg::ST_UPD_RD:
            begin
                state_next = lrc_pkg::ST_UPD_EX;
            end
            lrc_pkg::ST_UPD_EX:
            begin
                state_next = idx_last ? lrc_pkg::ST_DONE : lrc_pkg::ST_UPD_RD;
            end
            lrc_pkg::ST_MAP:
            begin
                state_next = idx_last ? lrc_pkg::ST_FIX_RD : lrc_pkg::ST_MAP;
            end
            lrc_pkg::ST_FIX_RD:
            begin
                state_next = lrc_pkg::ST_FIX_MAP;
            end
            lrc_pkg::ST_FIX_MAP:
            begin
                state_next = lrc_pkg::ST_FIX_EX;
            end
            lrc_pkg::ST_FIX_EX:
            begin
                state_next = idx_last ? lrc_pkg::ST_DONE : lrc_pkg::ST_FIX_RD;
            end
            lrc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = lrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = (state_reg == lrc_pkg::ST_IDLE);
        cfg_ready    = 1'b1;
        ent_wr_en    = 1'b0;
        rank_wr_en   = 1'b0;
        rank_wr_data = '0;
        map_wr_en    = 1'b0;
        map_wr_data  = IDX_W'(CNT_W'(idx_reg) - cum_reg);
        case (state_reg)
            lrc_pkg::ST_UPD_EX:
            begin
                if (idx_reg == slot_reg)
                begin
                    rank_wr_en = 1'b1;
                    ent_wr_en  = (req_reg == lrc_pkg::REQ_ADD);
                end
                else if (slot_valid && ((req_reg == lrc_pkg::REQ_ADD)
                                        || (rank_rd_data < hit_rank_reg)))
                begin
                    rank_wr_en   = 1'b1;
                    rank_wr_data = rank_rd_data + 1'b1;
                end
            end
            lrc_pkg::ST_MAP:
            begin
                map_wr_en = 1'b1;
            end
            lrc_pkg::ST_FIX_EX:
            begin
                rank_wr_en   = slot_valid;
                rank_wr_data = map_rd_data;
            end
            default:
            begin
                rank_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lrc_pkg::ST_IDLE;
            idx_reg         <= '0;
            valid_reg       <= '0;
            count_reg       <= '0;
            capacity_reg    <= lrc_pkg::CAP_RESET;
            kill_reg        <= '0;
            kill_rank_reg   <= '0;
            n_reg           <= '0;
            cum_reg         <= '0;
            hit_reg         <= 1'b0;
            victim_have_reg <= 1'b0;
            free_have_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if ((state_reg == lrc_pkg::ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                lrc_pkg::ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        idx_reg         <= '0;
                        kill_reg        <= '0;
                        kill_rank_reg   <= '0;
                        n_reg           <= '0;
                        cum_reg         <= '0;
                        hit_reg         <= 1'b0;
                        victim_have_reg <= 1'b0;
                        free_have_reg   <= 1'b0;
                    end
                end
                lrc_pkg::ST_SCAN_EX:
                begin
                    idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                    if (req_reg == lrc_pkg::REQ_DROP)
                    begin
                        if (tid_kill)
                        begin
                            kill_reg[idx_reg]           <= 1'b1;
                            kill_rank_reg[rank_rd_data] <= 1'b1;
                            n_reg                       <= n_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (key_eq)
                        begin
                            hit_reg <= 1'b1;
                        end
                        if (slot_valid && (!victim_have_reg || (rank_rd_data > best_reg)))
                        begin
                            victim_have_reg <= 1'b1;
                        end
                        if (!slot_valid)
                        begin
                            free_have_reg <= 1'b1;
                        end
                    end
                end
                lrc_pkg::ST_DECIDE:
                begin
                    if ((req_reg == lrc_pkg::REQ_ADD) && !hit_reg && !full)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    if (req_reg == lrc_pkg::REQ_DROP)
                    begin
                        valid_reg <= valid_reg & ~kill_reg;
                        count_reg <= count_reg - n_reg;
                    end
                end
                lrc_pkg::ST_UPD_EX:
                begin
                    idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                    if ((req_reg == lrc_pkg::REQ_ADD) && (idx_reg == slot_reg))
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                    end
                end
                lrc_pkg::ST_MAP:
                begin
                    idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                    if (kill_rank_reg[idx_reg])
                    begin
                        cum_reg <= cum_reg + 1'b1;
                    end
                end
                lrc_pkg::ST_FIX_EX:
                begin
                    idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lrc_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    req_reg          <= s_tuser;
                    in_reg           <= lrc_pkg::entry_t'(s_tdata[lrc_pkg::LRC_ENTRY_W-1:0]);
                    res_found_reg    <= 1'b0;
                    res_inserted_reg <= 1'b0;
                    res_handle_reg   <= '0;
                    res_removed_reg  <= '0;
                end
            end
            lrc_pkg::ST_SCAN_EX:
            begin
                if (key_eq && !hit_reg)
                begin
                    slot_reg       <= idx_reg;
                    hit_rank_reg   <= rank_rd_data;
                    hit_handle_reg <= ent_rd_data.handle;
                end
                if (slot_valid && (!victim_have_reg || (rank_rd_data > best_reg)))
                begin
                    victim_reg <= idx_reg;
                    best_reg   <= rank_rd_data;
                end
                if (!slot_valid && !free_have_reg)
                begin
                    free_reg <= idx_reg;
                end
            end
            lrc_pkg::ST_DECIDE:
            begin
                case (req_reg)
                    lrc_pkg::REQ_ADD:
                    begin
                        if (hit_reg)
                        begin
                            res_found_reg  <= 1'b1;
                            res_handle_reg <= hit_handle_reg;
                        end
                        else
                        begin
                            slot_reg         <= full ? victim_reg : free_reg;
                            res_inserted_reg <= 1'b1;
                        end
                    end
                    lrc_pkg::REQ_GET:
                    begin
                        if (hit_reg)
                        begin
                            res_found_reg  <= 1'b1;
                            res_handle_reg <= hit_handle_reg;
                        end
                    end
                    lrc_pkg::REQ_DROP:
                    begin
                        res_removed_reg <= (n_ext > CW'(lrc_pkg::REMOVED_MAX))
                                           ? lrc_pkg::REMOVED_MAX
                                           : n_ext[lrc_pkg::REMOVED_W-1:0];
                    end
                    default:
                    begin
                        res_found_reg <= 1'b0;
                    end
                endcase
            end
            lrc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {1'b0, res_removed_reg, res_handle_reg,
                                    res_inserted_reg, res_found_reg};
                end
            end
            default:
            begin
                slot_reg <= slot_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrc_pkg::ST_IDLE) |-> ($countones(valid_reg) == count_reg))
        else $error("entry count out of step with valid bits");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(count_reg) <= CAP_DEPTH)
        else $error("entry count above depth");

    a_kill_ranks_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrc_pkg::ST_MAP)
        |-> ($countones(kill_rank_reg) == $countones(kill_reg)))
        else $error("removed entries share a recency rank");

    a_update_only_add_get: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrc_pkg::ST_UPD_RD)
        |-> ((req_reg == lrc_pkg::REQ_ADD) || (req_reg == lrc_pkg::REQ_GET)))
        else $error("recency update pass on a drop or unused request");

endmodule

// ===== test/lru_result_cache_table_top_tb.sv =====
// ---------------------------------------------------------------------------
// lru_result_cache_table_top_tb
// Self-checking bench for the LRU result cache table. A queue-fed driver
// sends add, get, drop and unused-code requests in bursts. A shadow LRU
// store predicts every reply. The monitor checks the replies field by field
// while the receiver stalls at random. Capacity is swept across its range.
// ---------------------------------------------------------------------------
module lru_result_cache_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 600;
    localparam int PHASES = 10;
    localparam int PHASE_REQS = 190;

    typedef struct {
        logic [REQ_W-1:0] req;
        logic [KEY_W-1:0] key;
        logic [TID_W-1:0] tid;
        logic             drp;
        logic [HND_W-1:0] hnd;
    } cache_req_t;

    typedef struct packed {
        logic                 found;
        logic                 inserted;
        logic [HND_W-1:0]     handle;
        logic [REMOVED_W-1:0] removed;
    } reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [REQ_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CAP_W-1:0]      cfg_data = '0;

    lru_result_cache_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // shadow store
    bit   [LRC_DEPTH-1:0] slot_valid = '0;
    logic [KEY_W-1:0]     slot_key [LRC_DEPTH];
    logic [TID_W-1:0]     slot_tid [LRC_DEPTH];
    logic                 slot_drp [LRC_DEPTH];
    logic [HND_W-1:0]     slot_hnd [LRC_DEPTH];
    int                   slot_rank [LRC_DEPTH];
    int                   slot_count = 0;
    logic [CAP_W-1:0]     cap_shadow = CAP_RESET;

    cache_req_t request_q[$];
    reply_t     reply_q[$];
    logic [KEY_W-1:0] key_pool [24];
    logic [TID_W-1:0] tid_pool [4];

    int  queued_total = 0;
    int  accepted_total = 0;
    int  cfg_count = 0;
    int  err_count = 0;
    int  n_inserted = 0;
    int  n_hits = 0;
    int  n_dropped = 0;
    int  hold_ask = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  mode_left = 0;
    int  ready_pct = 100;
    logic in_fire = 1'b0;

    cache_req_t drv_req;
    cache_req_t mon_req;
    reply_t     mon_want;
    reply_t     mon_got;

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic int held_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < LRC_DEPTH; i++)
            if (slot_valid[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic reply_t lru_apply_request(input cache_req_t r);
        reply_t rep;
        int slot;
        int eff;
        int best;
        int hit_rank;
        int n;
        int below;
        bit [LRC_DEPTH-1:0] kill;
        rep = '0;
        eff = (cap_shadow == 0) ? 1 : ((cap_shadow > LRC_DEPTH) ? LRC_DEPTH : int'(cap_shadow));
        case (r.req)
            REQ_ADD:
            begin
                slot = held_slot(r.key);
                if (slot >= 0)
                begin
                    rep.found = 1'b1;
                    rep.handle = slot_hnd[slot];
                end
                else
                begin
                    if (slot_count >= eff && slot_count > 0)
                    begin
                        best = 0;
                        for (int i = 0; i < LRC_DEPTH; i++)
                            if (slot_valid[i] && (slot < 0 || slot_rank[i] > best))
                            begin
                                slot = i;
                                best = slot_rank[i];
                            end
                        slot_valid[slot] = 1'b0;
                        slot_count--;
                    end
                    else
                    begin
                        for (int i = 0; i < LRC_DEPTH; i++)
                            if (!slot_valid[i] && slot < 0)
                                slot = i;
                    end
                    if (slot >= 0)
                    begin
                        for (int i = 0; i < LRC_DEPTH; i++)
                            if (slot_valid[i])
                                slot_rank[i]++;
                        slot_valid[slot] = 1'b1;
                        slot_key[slot] = r.key;
                        slot_tid[slot] = r.tid;
                        slot_drp[slot] = r.drp;
                        slot_hnd[slot] = r.hnd;
                        slot_rank[slot] = 0;
                        slot_count++;
                        rep.inserted = 1'b1;
                    end
                end
            end
            REQ_GET:
            begin
                slot = held_slot(r.key);
                if (slot >= 0)
                begin
                    hit_rank = slot_rank[slot];
                    for (int i = 0; i < LRC_DEPTH; i++)
                        if (slot_valid[i] && slot_rank[i] < hit_rank)
                            slot_rank[i]++;
                    slot_rank[slot] = 0;
                    rep.found = 1'b1;
                    rep.handle = slot_hnd[slot];
                end
            end
            REQ_DROP:
            begin
                n = 0;
                for (int i = 0; i < LRC_DEPTH; i++)
                begin
                    kill[i] = slot_valid[i] && slot_drp[i] && slot_tid[i] == r.tid;
                    if (kill[i])
                        n++;
                end
                for (int i = 0; i < LRC_DEPTH; i++)
                begin
                    if (slot_valid[i] && !kill[i])
                    begin
                        below = 0;
                        for (int j = 0; j < LRC_DEPTH; j++)
                            if (kill[j] && slot_rank[j] < slot_rank[i])
                                below++;
                        slot_rank[i] -= below;
                    end
                end
                slot_valid &= ~kill;
                slot_count -= n;
                rep.removed = (n > 31) ? REMOVED_MAX : REMOVED_W'(n);
            end
            default:
            begin
            end
        endcase
        return rep;
    endfunction

    function automatic cache_req_t random_request(input int win);
        cache_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.req = REQ_ADD;
        else if (pick < 85)
            r.req = REQ_GET;
        else if (pick < 94)
            r.req = REQ_DROP;
        else
            r.req = REQ_UNUSED;
        r.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                             : key_pool[$urandom_range(0, win - 1)];
        r.tid = ($urandom_range(0, 9) == 0) ? $urandom : tid_pool[$urandom_range(0, 3)];
        r.drp = ($urandom_range(0, 3) != 0);
        r.hnd = $urandom;
        return r;
    endfunction

    task automatic queue_request(input cache_req_t r);
        request_q.insert(request_q.size(), r);
        queued_total++;
    endtask

    task automatic queue_fields(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                                input logic [TID_W-1:0] tid, input logic drp,
                                input logic [HND_W-1:0] hnd);
        cache_req_t r;
        r.req = req;
        r.key = key;
        r.tid = tid;
        r.drp = drp;
        r.hnd = hnd;
        queue_request(r);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        int seen;
        seen = cfg_count;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        while (cfg_count == seen)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (accepted_total != queued_total || reply_q.size() != 0);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_fire)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (request_q.size() != 0)
            begin
                drv_req = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= drv_req.req;
                s_tdata <= {7'b0, drv_req.hnd, drv_req.drp, drv_req.tid, drv_req.key};
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // reply receiver
    always @(negedge clk)
    begin
        if (hold_ask != hold_seen)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left <= $urandom_range(20, 200);
                case ($urandom_range(0, 2))
                    0: ready_pct <= 100;
                    1: ready_pct <= 75;
                    default: ready_pct <= 35;
                endcase
            end
            else
                mode_left <= mode_left - 1;
            m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
            begin
                cap_shadow = cfg_data;
                cfg_count++;
            end
            if (s_tvalid && s_tready)
            begin
                mon_req.req = s_tuser;
                mon_req.key = s_tdata[63:0];
                mon_req.tid = s_tdata[95:64];
                mon_req.drp = s_tdata[96];
                mon_req.hnd = s_tdata[128:97];
                reply_q.insert(reply_q.size(), lru_apply_request(mon_req));
                accepted_total++;
            end
            if (m_tvalid && m_tready)
            begin
                mon_got.found = m_tdata[0];
                mon_got.inserted = m_tdata[1];
                mon_got.handle = m_tdata[33:2];
                mon_got.removed = m_tdata[38:34];
                if (reply_q.size() == 0)
                    flag_error($sformatf("reply with no request outstanding: %h", m_tdata));
                else
                begin
                    mon_want = reply_q.pop_front();
                    if (mon_got.found !== mon_want.found)
                        flag_error($sformatf("found: want %0b got %b",
                                             mon_want.found, mon_got.found));
                    if (mon_got.inserted !== mon_want.inserted)
                        flag_error($sformatf("inserted: want %0b got %b",
                                             mon_want.inserted, mon_got.inserted));
                    if (mon_got.handle !== mon_want.handle)
                        flag_error($sformatf("result_handle: want %h got %h",
                                             mon_want.handle, mon_got.handle));
                    if (mon_got.removed !== mon_want.removed)
                        flag_error($sformatf("removed_count: want %0d got %0d",
                                             mon_want.removed, mon_got.removed));
                    if (m_tdata[39] !== 1'b0)
                        flag_error($sformatf("pad bit: got %b", m_tdata[39]));
                    if (mon_want.inserted)
                        n_inserted++;
                    if (mon_want.found)
                        n_hits++;
                    n_dropped += mon_want.removed;
                end
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [CAP_W-1:0] cap_plan [PHASES];
        logic [KEY_W-1:0] fill_base;
        int win;
        for (int i = 0; i < 24; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < 4; i++)
            tid_pool[i] = $urandom;
        fill_base = {$urandom, $urandom};
        cap_plan = '{5'd1, 5'd0, 5'd16, 5'd3, 5'd31, 5'd17, 5'd2, 5'd8, 5'd0, 5'd0};
        cap_plan[8] = $urandom_range(0, 31);
        cap_plan[9] = $urandom_range(4, 15);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty miss, duplicate add, both drop outcomes, unused code, full evict
        queue_fields(REQ_GET, '0, '0, 1'b0, '0);
        queue_fields(REQ_ADD, '0, '0, 1'b0, 32'h0000_1234);
        queue_fields(REQ_ADD, '1, '1, 1'b1, '1);
        queue_fields(REQ_ADD, '0, '1, 1'b1, 32'h0000_9999);
        queue_fields(REQ_GET, '1, '0, 1'b0, '0);
        queue_fields(REQ_DROP, '0, '1, 1'b0, '0);
        queue_fields(REQ_DROP, '1, '0, 1'b1, '1);
        queue_fields(REQ_UNUSED, '1, '1, 1'b1, '1);
        for (int i = 0; i < 16; i++)
            queue_fields(REQ_ADD, fill_base + i, tid_pool[0], 1'b1, $urandom);
        queue_fields(REQ_DROP, '0, tid_pool[0], 1'b0, '0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(cap_plan[p]);
            win = (p == 2) ? 24 : $urandom_range(2, 24);
            for (int i = 0; i < PHASE_REQS; i++)
                queue_request(random_request(win));
            if (p == 4)
                hold_ask++;
            drain();
        end

        repeat (6 * LRC_DEPTH + 4) @(posedge clk);
        $display("Covered %0d requests over %0d capacity writes (0, 1, 16, 17, 31 included).",
                 accepted_total, cfg_count);
        $display("Inserts %0d, hits %0d, entries dropped %0d, with one long output hold-off.",
                 n_inserted, n_hits, n_dropped);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
